// ===== src/pbvs_pkg.sv =====
// Shared types and constants for the packed bit vector store.
`default_nettype none

package pbvs_pkg;

	localparam int LEN_W           = 17;     // bit length / bit index width
	localparam int CNT_W           = 6;      // bit_count width
	localparam int DATA_W          = 32;     // value and slice width
	localparam int FUNC_W          = 3;
	localparam int ERR_W           = 3;
	localparam int SLICE_MAX       = 32;
	localparam int MAX_LEN         = 65536;
	localparam int STORE_WORDS_DEF = 2048;
	localparam int WORD_BITS_DEF   = 32;

	typedef enum logic [FUNC_W-1:0] {
		FN_START  = 3'd0,
		FN_APPEND = 3'd1,
		FN_SLICE  = 3'd2,
		FN_RDBIT  = 3'd3,
		FN_SETBIT = 3'd4,
		FN_CLRBIT = 3'd5
	} func_t;

	typedef enum logic [ERR_W-1:0] {
		ERR_NONE  = 3'd0,
		ERR_RANGE = 3'd1,
		ERR_ORDER = 3'd2,
		ERR_WIDE  = 3'd3,
		ERR_FULL  = 3'd4
	} err_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_REM,
		ST_RD,
		ST_MOD,
		ST_FIN
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic accept;     // latch request, check it, update length
		logic divide;     // quotient of bit position by word size
		logic remainder;  // word address and bit offset
		logic read;       // memory read of current word
		logic modify;     // merge/extract current word
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic skip;       // error or nothing to touch in memory
		logic last;       // current word finishes the request
	} status_t;

endpackage

`default_nettype wire

// ===== src/pbvs_ctrl.sv =====
// Controller state machine for the packed bit vector store.
`default_nettype none

module pbvs_ctrl (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   start,
	input  pbvs_pkg::status_t     status,
	output pbvs_pkg::cmd_t        cmd,
	output logic                  busy,
	output logic                  done
);

	pbvs_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pbvs_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		busy    = 1'b1;
		done    = 1'b0;
		unique case (state_q)
			pbvs_pkg::ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					cmd.accept = 1'b1;
					state_d    = pbvs_pkg::ST_DIV;
				end
			end
			pbvs_pkg::ST_DIV: begin
				cmd.divide = 1'b1;
				state_d    = status.skip ? pbvs_pkg::ST_FIN : pbvs_pkg::ST_REM;
			end
			pbvs_pkg::ST_REM: begin
				cmd.remainder = 1'b1;
				state_d       = pbvs_pkg::ST_RD;
			end
			pbvs_pkg::ST_RD: begin
				cmd.read = 1'b1;
				state_d  = pbvs_pkg::ST_MOD;
			end
			pbvs_pkg::ST_MOD: begin
				cmd.modify = 1'b1;
				state_d    = status.last ? pbvs_pkg::ST_FIN : pbvs_pkg::ST_RD;
			end
			pbvs_pkg::ST_FIN: begin
				// result on the ports this cycle; next request may be taken now
				done = 1'b1;
				busy = 1'b0;
				if (start) begin
					cmd.accept = 1'b1;
					state_d    = pbvs_pkg::ST_DIV;
				end else begin
					state_d = pbvs_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = pbvs_pkg::ST_IDLE;
			end
		endcase
	end

`ifndef SYNTHESIS
	a_done_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ($past(state_q) == pbvs_pkg::ST_DIV || $past(state_q) == pbvs_pkg::ST_MOD))
		else $error("result strobe without a finishing step");
`endif

endmodule

`default_nettype wire

// ===== src/pbvs_dp.sv =====
// Datapath of the packed bit vector store: request checks, word memory, merge and extract.
`default_nettype none

module pbvs_dp #(
	parameter int STORE_WORDS = pbvs_pkg::STORE_WORDS_DEF,
	parameter int WORD_BITS   = pbvs_pkg::WORD_BITS_DEF
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  pbvs_pkg::cmd_t               cmd,
	output pbvs_pkg::status_t            status,
	input  wire [pbvs_pkg::FUNC_W-1:0]   func,
	input  wire [pbvs_pkg::DATA_W-1:0]   word_value,
	input  wire [pbvs_pkg::CNT_W-1:0]    bit_count,
	input  wire [pbvs_pkg::LEN_W-1:0]    start_index,
	input  wire [pbvs_pkg::LEN_W-1:0]    end_index,
	output logic [pbvs_pkg::DATA_W-1:0]  read_data,
	output logic [pbvs_pkg::LEN_W-1:0]   bit_length,
	output logic [pbvs_pkg::ERR_W-1:0]   error_code
);

	localparam int LW  = pbvs_pkg::LEN_W;
	localparam int DW  = pbvs_pkg::DATA_W;
	localparam int CW  = pbvs_pkg::CNT_W;
	localparam int AW  = (STORE_WORDS > 1) ? $clog2(STORE_WORDS) : 1;
	localparam int OW  = $clog2(WORD_BITS);
	localparam int KW  = (OW + 1 > CW) ? OW + 1 : CW;
	localparam longint RAW_CAP = longint'(STORE_WORDS) * longint'(WORD_BITS);
	localparam longint CAP     = (RAW_CAP > longint'(pbvs_pkg::MAX_LEN)) ?
		longint'(pbvs_pkg::MAX_LEN) : RAW_CAP;
	localparam logic [LW:0] CAP_L = (LW + 1)'(CAP);
	// position / WORD_BITS by reciprocal: exact for every LW-bit position
	localparam int DIV_SHIFT = LW + OW;
	localparam int MW        = LW + 2;
	localparam longint DIV_MULT = (longint'(1) << DIV_SHIFT) / WORD_BITS + 1;

	// request registers
	logic [LW-1:0]        pos_q;
	logic [CW-1:0]        n_q;
	logic [DW-1:0]        val_q;
	logic                 is_wr_q;
	pbvs_pkg::err_t       err_q;
	logic [LW-1:0]        len_q;
	logic [DW-1:0]        acc_q;
	logic [CW-1:0]        got_q;
	// word walk
	logic [LW-1:0]        q_q;
	logic [AW-1:0]        addr_q;
	logic [OW-1:0]        off_q;
	logic [WORD_BITS-1:0] rdata_q;

	logic [WORD_BITS-1:0] mem [STORE_WORDS];

	// request decode
	pbvs_pkg::err_t       err_d;
	logic [LW-1:0]        pos_d;
	logic [CW-1:0]        n_d;
	logic [DW-1:0]        val_d;
	logic                 wr_d;
	logic                 upd_d;
	logic [LW-1:0]        newlen_d;
	logic [LW:0]          sum_d;
	logic [LW:0]          span_d;

	assign sum_d  = {1'b0, len_q} + (LW + 1)'(bit_count);
	assign span_d = {1'b0, end_index} - {1'b0, start_index};

	always_comb begin
		err_d    = pbvs_pkg::ERR_NONE;
		pos_d    = start_index;
		n_d      = '0;
		val_d    = word_value;
		wr_d     = 1'b0;
		upd_d    = 1'b0;
		newlen_d = len_q;
		unique case (pbvs_pkg::func_t'(func))
			pbvs_pkg::FN_START: begin
				if (bit_count > CW'(pbvs_pkg::SLICE_MAX)) begin
					err_d = pbvs_pkg::ERR_RANGE;
				end else if ((LW + 1)'(bit_count) > CAP_L) begin
					err_d = pbvs_pkg::ERR_FULL;
				end else begin
					pos_d    = '0;
					n_d      = bit_count;
					wr_d     = 1'b1;
					upd_d    = 1'b1;
					newlen_d = LW'(bit_count);
				end
			end
			pbvs_pkg::FN_APPEND: begin
				if (bit_count > CW'(pbvs_pkg::SLICE_MAX)) begin
					err_d = pbvs_pkg::ERR_RANGE;
				end else if (sum_d > CAP_L) begin
					err_d = pbvs_pkg::ERR_FULL;
				end else begin
					pos_d    = len_q;
					n_d      = bit_count;
					wr_d     = 1'b1;
					upd_d    = 1'b1;
					newlen_d = sum_d[LW-1:0];
				end
			end
			pbvs_pkg::FN_SLICE: begin
				if (end_index < start_index) begin
					err_d = pbvs_pkg::ERR_ORDER;
				end else if (span_d > (LW + 1)'(pbvs_pkg::SLICE_MAX)) begin
					err_d = pbvs_pkg::ERR_WIDE;
				end else if (span_d == '0) begin
					n_d = '0;  // empty slice reads as zero anywhere
				end else if (end_index > len_q) begin
					err_d = pbvs_pkg::ERR_RANGE;
				end else begin
					n_d = span_d[CW-1:0];
				end
			end
			pbvs_pkg::FN_RDBIT, pbvs_pkg::FN_SETBIT, pbvs_pkg::FN_CLRBIT: begin
				if (start_index >= len_q) begin
					err_d = pbvs_pkg::ERR_RANGE;
				end else begin
					n_d   = CW'(1);
					wr_d  = (pbvs_pkg::func_t'(func) != pbvs_pkg::FN_RDBIT);
					val_d = (pbvs_pkg::func_t'(func) == pbvs_pkg::FN_SETBIT) ?
						DW'(1) : '0;
				end
			end
			default: begin
				n_d = '0;  // unused selector: no effect
			end
		endcase
	end

	// per-word merge / extract
	logic [KW-1:0]          avail;
	logic [KW-1:0]          k;
	logic [WORD_BITS:0]     one_sh;
	logic [WORD_BITS-1:0]   lo_mask;
	logic [WORD_BITS-1:0]   wmask;
	logic [WORD_BITS+DW-1:0] vext;
	logic [WORD_BITS-1:0]   val_w;
	logic [WORD_BITS-1:0]   new_word;
	logic [WORD_BITS-1:0]   field_w;
	logic [WORD_BITS+DW-1:0] fext;
	logic [DW-1:0]          field32;
	logic [LW+MW-1:0]       prod;
	logic [LW-1:0]          qw;
	logic [LW-1:0]          rem;

	assign avail    = KW'(WORD_BITS) - KW'(off_q);
	assign k        = (KW'(n_q) < avail) ? KW'(n_q) : avail;
	// full-width field gives an all-ones mask
	assign one_sh   = (WORD_BITS + 1)'(1) << k;
	assign lo_mask  = WORD_BITS'(one_sh - (WORD_BITS + 1)'(1));
	assign wmask    = lo_mask << off_q;
	assign vext     = {{WORD_BITS{1'b0}}, val_q};
	assign val_w    = vext[WORD_BITS-1:0];
	assign new_word = (rdata_q & ~wmask) | ((val_w << off_q) & wmask);
	assign field_w  = (rdata_q >> off_q) & lo_mask;
	assign fext     = {{DW{1'b0}}, field_w};
	assign field32  = fext[DW-1:0];
	assign prod     = (LW + MW)'(pos_q) * (LW + MW)'(MW'(DIV_MULT));
	assign qw       = q_q * LW'(WORD_BITS);
	assign rem      = pos_q - qw;

	assign status.skip = (err_q != pbvs_pkg::ERR_NONE) || (n_q == '0);
	assign status.last = (KW'(n_q) <= avail);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q   <= '0;
			err_q   <= pbvs_pkg::ERR_NONE;
			acc_q   <= '0;
			is_wr_q <= 1'b0;
		end else if (cmd.accept) begin
			err_q   <= err_d;
			acc_q   <= '0;
			is_wr_q <= wr_d;
			if (upd_d) begin
				len_q <= newlen_d;
			end
		end else if (cmd.modify && !is_wr_q) begin
			acc_q <= acc_q | (field32 << got_q);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			pos_q <= pos_d;
			n_q   <= n_d;
			val_q <= val_d;
			got_q <= '0;
		end
		if (cmd.divide) begin
			q_q <= LW'(prod >> DIV_SHIFT);
		end
		if (cmd.remainder) begin
			addr_q <= q_q[AW-1:0];
			off_q  <= rem[OW-1:0];
		end
		if (cmd.read) begin
			rdata_q <= mem[addr_q];
		end
		if (cmd.modify) begin
			n_q    <= n_q - CW'(k);
			got_q  <= got_q + CW'(k);
			val_q  <= val_q >> k;
			off_q  <= '0;
			addr_q <= addr_q + AW'(1);
			if (is_wr_q) begin
				mem[addr_q] <= new_word;
			end
		end
	end

	assign read_data  = acc_q;
	assign bit_length = len_q;
	assign error_code = err_q;

`ifndef SYNTHESIS
	a_len_cap: assert property (@(posedge clk) disable iff (!arst_n)
		(LW + 1)'(len_q) <= CAP_L)
		else $error("vector length above capacity");

	a_err_keeps_len: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.accept && err_d != pbvs_pkg::ERR_NONE) |=> (len_q == $past(len_q)))
		else $error("faulty request changed the length");

	a_walk_bits: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.read || cmd.modify) |-> ((CW + 1)'(got_q) + (CW + 1)'(n_q) <=
			(CW + 1)'(pbvs_pkg::SLICE_MAX)))
		else $error("word walk moved more bits than requested");
`endif

endmodule

`default_nettype wire

// ===== src/packed_bit_vector_store_top.sv =====
// Top level of the packed bit vector store: controller plus datapath.
//
// Channel   Direction  Handshake                      Payload
// request   in         start & !busy at clock edge    func, word_value, bit_count,
//                                                     start_index, end_index
// result    out        done, one cycle, no backpress. read_data, bit_length, error_code
//
// Steps: a request that touches w memory words (w is 1 or 2 for 32-bit
// words) goes through accept, divide and remainder, then a read step and
// a merge/extract (and write-back) step per word; the result strobes in the
// finishing state that follows. A rejected request or one that touches no
// word goes from divide straight to the finishing state. The single-port
// word memory sets this order: each word needs its own read and merge step.
// busy drops in the cycle the result is shown, so a new request can be
// transferred on the same edge the result is taken.
// Reset clears the length, status outputs and controller; the word memory
// is not cleared, as bits at or past the length are never observed.
`default_nettype none

module packed_bit_vector_store_top #(
	parameter int STORE_WORDS = pbvs_pkg::STORE_WORDS_DEF,
	parameter int WORD_BITS   = pbvs_pkg::WORD_BITS_DEF
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          start,
	output logic                         busy,
	input  wire [pbvs_pkg::FUNC_W-1:0]   func,
	input  wire [pbvs_pkg::DATA_W-1:0]   word_value,
	input  wire [pbvs_pkg::CNT_W-1:0]    bit_count,
	input  wire [pbvs_pkg::LEN_W-1:0]    start_index,
	input  wire [pbvs_pkg::LEN_W-1:0]    end_index,
	output logic                         done,
	output logic [pbvs_pkg::DATA_W-1:0]  read_data,
	output logic [pbvs_pkg::LEN_W-1:0]   bit_length,
	output logic [pbvs_pkg::ERR_W-1:0]   error_code
);

	pbvs_pkg::cmd_t    cmd;
	pbvs_pkg::status_t status;

	// sequencing: accept, divide, remainder, then read/modify per word
	pbvs_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.status (status),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	// checks, length register, word memory and the bit merge/extract logic
	pbvs_dp #(
		.STORE_WORDS (STORE_WORDS),
		.WORD_BITS   (WORD_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.status      (status),
		.func        (func),
		.word_value  (word_value),
		.bit_count   (bit_count),
		.start_index (start_index),
		.end_index   (end_index),
		.read_data   (read_data),
		.bit_length  (bit_length),
		.error_code  (error_code)
	);

endmodule

`default_nettype wire

// ===== dv/packed_bit_vector_store_top_tb.sv =====
// Self-checking testbench for the packed bit vector store top level.
module packed_bit_vector_store_top_tb;
	import pbvs_pkg::*;

	localparam int unsigned STORE_WORDS = STORE_WORDS_DEF;
	localparam int unsigned WORD_BITS   = WORD_BITS_DEF;
	localparam int unsigned CAPACITY    =
		(STORE_WORDS * WORD_BITS > MAX_LEN) ? MAX_LEN : STORE_WORDS * WORD_BITS;
	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int unsigned TAIL_CYCLES = 16;
	localparam int unsigned LEN_SOFT_CAP = 3000;

	// selector codes the block does not decode
	localparam logic [FUNC_W-1:0] FN_SPARE_A = 3'd6;
	localparam logic [FUNC_W-1:0] FN_SPARE_B = 3'd7;

	typedef struct {
		logic [DATA_W-1:0] data;
		logic [LEN_W-1:0]  len;
		err_t              err;
	} store_result_t;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                start;
	logic                busy;
	logic [FUNC_W-1:0]   func;
	logic [DATA_W-1:0]   word_value;
	logic [CNT_W-1:0]    bit_count;
	logic [LEN_W-1:0]    start_index;
	logic [LEN_W-1:0]    end_index;
	logic                done;
	logic [DATA_W-1:0]   read_data;
	logic [LEN_W-1:0]    bit_length;
	logic [ERR_W-1:0]    error_code;

	// mirror of the word store and the vector length
	logic [WORD_BITS-1:0] store_mirror [STORE_WORDS];
	int unsigned          mirror_len;

	store_result_t pending_results [$];
	int unsigned   fail_count;
	int unsigned   cycle_count;
	bit            gaps_on;

	packed_bit_vector_store_top DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.func        (func),
		.word_value  (word_value),
		.bit_count   (bit_count),
		.start_index (start_index),
		.end_index   (end_index),
		.done        (done),
		.read_data   (read_data),
		.bit_length  (bit_length),
		.error_code  (error_code)
	);

	always #1 clk = ~clk;

	// watchdog: a hung handshake ends the run as a failure
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("packed_bit_vector_store_top: mismatch");
			$finish;
		end
	end

	function automatic logic mirror_bit(input int unsigned pos);
		if (pos / WORD_BITS >= STORE_WORDS)
			return 1'b0;
		return store_mirror[pos / WORD_BITS][pos % WORD_BITS];
	endfunction

	function automatic void mirror_put(input int unsigned pos, input logic v);
		if (pos / WORD_BITS < STORE_WORDS)
			store_mirror[pos / WORD_BITS][pos % WORD_BITS] = v;
	endfunction

	function automatic void mirror_write(input int unsigned base, input logic [DATA_W-1:0] val,
			input int unsigned cnt);
		for (int unsigned i = 0; i < cnt; i++)
			mirror_put(base + i, val[i]);
	endfunction

	// adds one expected result at the tail of the queue
	function automatic void queue_result(input store_result_t r);
		pending_results = {pending_results, r};
	endfunction

	// Applies one transfer to the mirror and queues the result it must produce.
	function automatic void apply_store_op(input logic [FUNC_W-1:0] fn,
			input logic [DATA_W-1:0] val, input logic [CNT_W-1:0] cnt,
			input logic [LEN_W-1:0] si, input logic [LEN_W-1:0] ei);
		store_result_t r;
		int unsigned s;
		int unsigned e;
		r.data = '0;
		r.err  = ERR_NONE;
		s = si;
		e = ei;
		case (fn)
			FN_START: begin
				if (cnt > SLICE_MAX)
					r.err = ERR_RANGE;
				else if (cnt > CAPACITY)
					r.err = ERR_FULL;
				else begin
					mirror_write(0, val, cnt);
					mirror_len = cnt;
				end
			end
			FN_APPEND: begin
				if (cnt > SLICE_MAX)
					r.err = ERR_RANGE;
				else if (mirror_len + cnt > CAPACITY)
					r.err = ERR_FULL;
				else begin
					mirror_write(mirror_len, val, cnt);
					mirror_len += cnt;
				end
			end
			FN_SLICE: begin
				if (e < s)
					r.err = ERR_ORDER;
				else if (e - s > SLICE_MAX)
					r.err = ERR_WIDE;
				else if (e == s)
					r.data = '0;
				else if (e > mirror_len)
					r.err = ERR_RANGE;
				else begin
					for (int unsigned i = 0; i < e - s; i++)
						r.data[i] = mirror_bit(s + i);
				end
			end
			FN_RDBIT, FN_SETBIT, FN_CLRBIT: begin
				if (s >= mirror_len)
					r.err = ERR_RANGE;
				else if (fn == FN_RDBIT)
					r.data[0] = mirror_bit(s);
				else
					mirror_put(s, fn == FN_SETBIT);
			end
			default: ;
		endcase
		r.len = mirror_len[LEN_W-1:0];
		queue_result(r);
	endfunction

	// Result checker: done is a one-cycle strobe, taken at the edge ending it.
	always @(posedge clk) begin : check_result
		store_result_t want;
		if (arst_n === 1'b1 && done === 1'b1) begin
			if (pending_results.size() == 0) begin
				$error("result with no transfer outstanding: data %h len %0d err %0d",
					read_data, bit_length, error_code);
				fail_count++;
			end else begin
				want = pending_results.pop_front();
				if (read_data !== want.data) begin
					$error("read_data: expected %h, actual %h", want.data, read_data);
					fail_count++;
				end
				if (bit_length !== want.len) begin
					$error("bit_length: expected %0d, actual %0d", want.len, bit_length);
					fail_count++;
				end
				if (error_code !== want.err) begin
					$error("error_code: expected %0d, actual %0d", want.err, error_code);
					fail_count++;
				end
			end
		end
	end

	// One request transfer; start is left high so back-to-back items need no toggle.
	task automatic send_op(input logic [FUNC_W-1:0] fn, input logic [DATA_W-1:0] val,
			input logic [CNT_W-1:0] cnt, input logic [LEN_W-1:0] si,
			input logic [LEN_W-1:0] ei);
		@(negedge clk);
		start       <= 1'b1;
		func        <= fn;
		word_value  <= val;
		bit_count   <= cnt;
		start_index <= si;
		end_index   <= ei;
		@(posedge clk);
		while (busy !== 1'b0)
			@(posedge clk);
		apply_store_op(fn, val, cnt, si, ei);
	endtask

	task automatic idle_sender(input int unsigned cycles);
		@(negedge clk);
		start <= 1'b0;
		repeat (cycles - 1) @(negedge clk);
	endtask

	task automatic random_gap(input int unsigned odds);
		if (gaps_on && $urandom_range(0, odds - 1) == 0)
			idle_sender($urandom_range(1, 14));
	endtask

	task automatic wait_results_drained;
		@(negedge clk);
		start <= 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
	endtask

	// Mostly well-formed requests against the current length, plus some noise.
	task automatic random_op;
		int unsigned sel;
		int unsigned len;
		int unsigned n;
		int unsigned s;
		int unsigned e;
		logic [DATA_W-1:0] val;
		sel = $urandom_range(0, 99);
		len = mirror_len;
		val = $urandom;
		if (len == 0 && sel >= 35 && sel < 86)
			sel = 10;
		if (sel < 35 && sel >= 5 && len > LEN_SOFT_CAP)
			sel = 0;
		if (sel < 5) begin
			send_op(FN_START, val, $urandom_range(0, 32), $urandom_range(0, 65536),
				$urandom_range(0, 65536));
		end else if (sel < 35) begin
			send_op(FN_APPEND, val, $urandom_range(0, 32), $urandom_range(0, 65536),
				$urandom_range(0, 65536));
		end else if (sel < 60) begin
			n = $urandom_range(1, (len < SLICE_MAX) ? len : SLICE_MAX);
			s = $urandom_range(0, len - n);
			e = s + n;
			send_op(FN_SLICE, val, $urandom_range(0, 63), s, e);
		end else if (sel < 72) begin
			send_op(FN_RDBIT, val, $urandom_range(0, 63), $urandom_range(0, len - 1),
				$urandom_range(0, 65536));
		end else if (sel < 86) begin
			send_op(($urandom_range(0, 1) != 0) ? FN_SETBIT : FN_CLRBIT, val,
				$urandom_range(0, 63), $urandom_range(0, len - 1), $urandom_range(0, 65536));
		end else begin
			// noise: any selector and count, indices near the end or anywhere
			if ($urandom_range(0, 1) != 0) begin
				s = $urandom_range(0, 65536);
				e = $urandom_range(0, 65536);
			end else begin
				s = ((len > 20) ? len - 20 : 0) + $urandom_range(0, 40);
				e = s + $urandom_range(0, 40);
				if ($urandom_range(0, 3) == 0)
					e = (s > 3) ? s - $urandom_range(1, 3) : e;
			end
			send_op($urandom_range(0, 7), val, $urandom_range(0, 63), s, e);
		end
	endtask

	task automatic test_directed_cases;
		// empty vector: every index is out of range, empty slices still pass
		send_op(FN_RDBIT,  '0, '0, 17'd0, 17'd0);
		send_op(FN_SLICE,  '0, '0, 17'd0, 17'd0);
		send_op(FN_SLICE,  '0, '0, 17'd65536, 17'd65536);
		send_op(FN_START,  32'hFFFF_FFFF, 6'd0, 17'd0, 17'd0);
		// counts above 32
		send_op(FN_START,  32'hFFFF_FFFF, 6'd33, 17'd0, 17'd0);
		send_op(FN_START,  32'hFFFF_FFFF, 6'd63, 17'd0, 17'd0);
		// start value masked to its count: stale ones must not leak into the append
		send_op(FN_START,  32'hFFFF_FFFF, 6'd5, 17'd0, 17'd0);
		send_op(FN_APPEND, 32'hAAAA_AAAA, 6'd32, 17'd0, 17'd0);
		send_op(FN_SLICE,  '0, '0, 17'd0, 17'd32);
		send_op(FN_SLICE,  '0, '0, 17'd5, 17'd37);
		send_op(FN_SLICE,  '0, '0, 17'd3, 17'd35);
		send_op(FN_APPEND, 32'h5555_5555, 6'd33, 17'd0, 17'd0);
		send_op(FN_APPEND, 32'h5555_5555, 6'd0, 17'd0, 17'd0);
		// reversed, over-wide, and past-the-end slices
		send_op(FN_SLICE,  '0, '0, 17'd10, 17'd5);
		send_op(FN_SLICE,  '0, '0, 17'd0, 17'd33);
		send_op(FN_SLICE,  '0, '0, 17'd30, 17'd38);
		// single-bit ops at and beyond the last bit
		send_op(FN_RDBIT,  '0, '0, 17'd36, 17'd0);
		send_op(FN_RDBIT,  '0, '0, 17'd37, 17'd0);
		send_op(FN_CLRBIT, '0, '0, 17'd36, 17'd0);
		send_op(FN_CLRBIT, '0, '0, 17'd0, 17'd0);
		send_op(FN_SETBIT, '0, '0, 17'd5, 17'd0);
		send_op(FN_SETBIT, '0, '0, 17'd37, 17'd0);
		send_op(FN_CLRBIT, '0, '0, 17'd65536, 17'd0);
		send_op(FN_SLICE,  '0, '0, 17'd4, 17'd37);
		// undecoded selectors do nothing
		send_op(FN_SPARE_A, 32'hFFFF_FFFF, 6'd63, 17'd65536, 17'd65536);
		send_op(FN_SPARE_B, 32'h1234_5678, 6'd32, 17'd0, 17'd0);
		send_op(FN_SLICE,  '0, '0, 17'd0, 17'd32);
	endtask

	task automatic test_random_mix;
		for (int i = 0; i < 1100; i++) begin
			if (i % 100 == 0)
				gaps_on = ($urandom_range(0, 3) != 0);
			random_op();
			random_gap(3);
			// hold off once until the block has answered everything
			if (i == 550)
				wait_results_drained();
		end
	endtask

	task automatic test_back_to_back;
		gaps_on = 1'b0;
		if (mirror_len > LEN_SOFT_CAP)
			send_op(FN_START, $urandom, 6'd32, 17'd0, 17'd0);
		for (int i = 0; i < 150; i++)
			random_op();
	endtask

	initial begin
		arst_n      = 1'b0;
		start       = 1'b0;
		func        = FN_START;
		word_value  = '0;
		bit_count   = '0;
		start_index = '0;
		end_index   = '0;
		fail_count  = 0;
		cycle_count = 0;
		mirror_len  = 0;
		gaps_on     = 1'b1;
		for (int i = 0; i < STORE_WORDS; i++)
			store_mirror[i] = '0;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_directed_cases();
		wait_results_drained();
		test_random_mix();
		wait_results_drained();
		test_back_to_back();
		wait_results_drained();
		repeat (TAIL_CYCLES) @(negedge clk);

		if (pending_results.size() != 0) begin
			$error("%0d results never arrived", pending_results.size());
			fail_count++;
		end
		if (fail_count == 0)
			$display("packed_bit_vector_store_top: match");
		else
			$display("packed_bit_vector_store_top: mismatch");
		$finish;
	end

endmodule
